/* sv/pmu_pkg.sv */
// ----------------------------------------------------------------------------
// pmu_pkg
// Types and register codes shared by the mode update pipeline and its
// checker, and the clause evaluation used by the pipeline.
// ----------------------------------------------------------------------------
package pmu_pkg;

  localparam int MaxSlots    = 4;
  localparam int SlotW       = 16;
  localparam int ClausesW    = MaxSlots * SlotW;
  localparam int ControlW    = 17;
  localparam int ModeW       = 12;
  localparam int IdW         = 32;
  localparam int CountW      = 3;
  localparam int UmaskW      = 9;
  localparam int CfgIndexW   = 3;
  localparam int CfgDataW    = 64;
  localparam int InDataW     = 80;
  localparam int InUserW     = 2;
  localparam int OutDataW    = 16;

  localparam logic [UmaskW-1:0] UmaskReset = 9'o022;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_FILE_CLAUSES = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_FILE_CONTROL = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_DIR_CLAUSES  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_DIR_CONTROL  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_UMASK        = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_TARGET_OWNER = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_TARGET_GROUP = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_OWN_ENABLE   = 3'd7;

  // Clause operators
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Copy sources
  localparam logic [1:0] COPY_NONE = 2'd0;
  localparam logic [1:0] COPY_U    = 2'd1;
  localparam logic [1:0] COPY_G    = 2'd2;
  localparam logic [1:0] COPY_O    = 2'd3;

  localparam logic [ModeW-1:0] ExecAny   = 12'o0111;
  localparam logic [ModeW-1:0] SetidBits = 12'o6000;

  // One entry in flight
  typedef struct packed {
    logic [ModeW-1:0]  cur_mode;
    logic [ModeW-1:0]  work_mode;
    logic [ModeW-1:0]  oct_mode;
    logic              is_dir;
    logic              apply;
    logic              octal;
    logic [CountW-1:0] count;
    logic              owner_chg;
    logic              group_chg;
  } pmu_item_t;

  // One symbolic clause applied to a mode
  function automatic logic [ModeW-1:0] run_clause(
    input logic [ModeW-1:0]  m,
    input logic [SlotW-1:0]  slot,
    input logic              dir,
    input logic [UmaskW-1:0] um
  );
    logic [2:0]       who_f;
    logic [2:0]       who;
    logic [1:0]       op;
    logic [2:0]       rwx;
    logic             xc;
    logic             sb;
    logic             tb;
    logic [1:0]       cp;
    logic [ModeW-1:0] bits;
    logic [ModeW-1:0] clr;
    logic [ModeW-1:0] res;
    who_f = slot[2:0];
    op    = slot[4:3];
    rwx   = slot[7:5];
    xc    = slot[8];
    sb    = slot[9];
    tb    = slot[10];
    cp    = slot[12:11];
    who   = (who_f != 3'd0) ? who_f : 3'b111;

    case (cp)
      COPY_U:  rwx = m[8:6];
      COPY_G:  rwx = m[5:3];
      COPY_O:  rwx = m[2:0];
      default: rwx = rwx;
    endcase
    if (xc && (dir || ((m & ExecAny) != '0))) rwx[0] = 1'b1;

    bits = '0;
    if (who[0]) bits[8:6] = rwx;
    if (who[1]) bits[5:3] = rwx;
    if (who[2]) bits[2:0] = rwx;
    if (sb && who[0]) bits[11] = 1'b1;
    if (sb && who[1]) bits[10] = 1'b1;
    if (tb) bits[9] = 1'b1;
    if (who_f == 3'd0) bits[8:0] = bits[8:0] & ~um;

    clr = '0;
    if (who[0]) clr = clr | 12'o4700;
    if (who[1]) clr = clr | 12'o2070;
    if (who[2]) clr = clr | 12'o1007;
    if (dir && !sb) clr = clr & ~SetidBits;

    unique case (op)
      OP_ADD:  res = m | bits;
      OP_SUB:  res = m & ~bits;
      OP_SET:  res = (m & ~clr) | bits;
      default: res = m;
    endcase
    return res;
  endfunction

endpackage

/* sv/permission_mode_update.sv */
// ----------------------------------------------------------------------------
// permission_mode_update
// Computes the new permission mode of a file entry from an octal or a
// symbolic chmod spec, and flags mode, owner and group changes.
// ----------------------------------------------------------------------------
//
//  channel  | dir | signals                      | contents
//  ---------+-----+------------------------------+------------------------------
//  s_       | in  | tvalid tready tdata tuser    | one file entry
//  m_       | out | tvalid tready tdata          | new mode and change flags
//  cfg_     | in  | we index data                | spec, umask, ownership regs
//
//  One entry enters per cycle unless a stalled output backs the pipe up; an
//  entry passes an input stage (spec select, id compares), one stage per
//  clause slot, and the output register with the mode compare.
//  Each stage holds its own valid bit and moves when the stage after it is
//  empty or moving, so bubbles close up behind a stalled output.
//  rst clears all valid bits and loads the register reset values.
//  Configuration is read live by the input and clause stages; the user must
//  write it only while idle, which the block itself does not enforce.
module permission_mode_update #(
  parameter int CLAUSE_SLOTS = pmu_pkg::MaxSlots
) (
  input  logic                            clk,
  input  logic                            rst,
  // [11:0] current_mode, [43:12] owner_id, [75:44] group_id, [79:76] zero
  input  logic [pmu_pkg::InDataW-1:0]     s_tdata,
  // [0] is_dir, [1] is_link
  input  logic [pmu_pkg::InUserW-1:0]     s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [11:0] final mode, [12] mode_changes, [13] owner_changes,
  // [14] group_changes, [15] zero
  output logic [pmu_pkg::OutDataW-1:0]    m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [pmu_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [pmu_pkg::CfgDataW-1:0]    cfg_data
);

  localparam logic [pmu_pkg::CountW-1:0] SlotsC = pmu_pkg::CountW'(CLAUSE_SLOTS);

  // Configuration registers
  logic [pmu_pkg::ClausesW-1:0] file_clauses;
  logic [pmu_pkg::ControlW-1:0] file_control;
  logic [pmu_pkg::ClausesW-1:0] dir_clauses;
  logic [pmu_pkg::ControlW-1:0] dir_control;
  logic [pmu_pkg::UmaskW-1:0]   umask_bits;
  logic [pmu_pkg::IdW-1:0]      target_owner;
  logic [pmu_pkg::IdW-1:0]      target_group;
  logic [1:0]                   ownership_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_clauses     <= '0;
      file_control     <= '0;
      dir_clauses      <= '0;
      dir_control      <= '0;
      umask_bits       <= pmu_pkg::UmaskReset;
      target_owner     <= '0;
      target_group     <= '0;
      ownership_enable <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmu_pkg::REG_FILE_CLAUSES: file_clauses <= cfg_data;
        pmu_pkg::REG_FILE_CONTROL: file_control <= cfg_data[pmu_pkg::ControlW-1:0];
        pmu_pkg::REG_DIR_CLAUSES:  dir_clauses  <= cfg_data;
        pmu_pkg::REG_DIR_CONTROL:  dir_control  <= cfg_data[pmu_pkg::ControlW-1:0];
        pmu_pkg::REG_UMASK:        umask_bits   <= cfg_data[pmu_pkg::UmaskW-1:0];
        pmu_pkg::REG_TARGET_OWNER: target_owner <= cfg_data[pmu_pkg::IdW-1:0];
        pmu_pkg::REG_TARGET_GROUP: target_group <= cfg_data[pmu_pkg::IdW-1:0];
        pmu_pkg::REG_OWN_ENABLE:   ownership_enable <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage chain: index 0 is the input stage, index k+1 follows clause k
  logic               stg_valid [CLAUSE_SLOTS+1];
  logic               stg_ready [CLAUSE_SLOTS+1];
  pmu_pkg::pmu_item_t stg_item  [CLAUSE_SLOTS+1];

  // ---- Input stage: pick the spec, saturate the clause count, compare ids
  logic [pmu_pkg::ControlW-1:0] ctl_sel;
  logic [pmu_pkg::CountW-1:0]   raw_count;
  pmu_pkg::pmu_item_t           in_item;
  logic                         ent_valid;
  pmu_pkg::pmu_item_t           ent_item;

  always_comb begin
    ctl_sel   = s_tuser[0] ? dir_control : file_control;
    raw_count = ctl_sel[4:2];
    in_item.cur_mode  = s_tdata[11:0];
    in_item.work_mode = s_tdata[11:0];
    in_item.oct_mode  = ctl_sel[16:5];
    in_item.is_dir    = s_tuser[0];
    in_item.apply     = ctl_sel[0] && !s_tuser[1];   // links keep their mode
    in_item.octal     = ctl_sel[1];
    in_item.count     = (raw_count > SlotsC) ? SlotsC : raw_count;
    in_item.owner_chg = ownership_enable[0] && (s_tdata[43:12] != target_owner);
    in_item.group_chg = ownership_enable[1] && (s_tdata[75:44] != target_group);
  end

  assign s_tready = !ent_valid || stg_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (s_tready) begin
      ent_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      ent_item <= in_item;
    end
  end

  assign stg_valid[0] = ent_valid;
  assign stg_item[0]  = ent_item;

  // ---- Clause stages
  for (genvar k = 0; k < CLAUSE_SLOTS; k++) begin : g_clause
    pmu_clause_stage #(
      .SLOT_IDX (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .in_item   (stg_item[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .out_item  (stg_item[k+1]),
      .file_slot (file_clauses[k*pmu_pkg::SlotW +: pmu_pkg::SlotW]),
      .dir_slot  (dir_clauses[k*pmu_pkg::SlotW +: pmu_pkg::SlotW]),
      .umask     (umask_bits)
    );
  end

  // ---- Output register: final mode select and change compare
  pmu_pkg::pmu_item_t          last_item;
  logic [pmu_pkg::ModeW-1:0]   final_mode;

  assign last_item = stg_item[CLAUSE_SLOTS];
  assign stg_ready[CLAUSE_SLOTS] = !m_tvalid || m_tready;

  always_comb begin
    if (!last_item.apply) begin
      final_mode = last_item.cur_mode;
    end else if (last_item.octal) begin
      final_mode = last_item.oct_mode;
    end else begin
      final_mode = last_item.work_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stg_ready[CLAUSE_SLOTS]) begin
      m_tvalid <= stg_valid[CLAUSE_SLOTS];
    end
    if (stg_ready[CLAUSE_SLOTS] && stg_valid[CLAUSE_SLOTS]) begin
      m_tdata <= {1'b0, last_item.group_chg, last_item.owner_chg,
                  final_mode != last_item.cur_mode, final_mode};
    end
  end

endmodule

/* sv/pmu_clause_stage.sv */
// ----------------------------------------------------------------------------
// pmu_clause_stage
// One pipeline stage applying one symbolic clause slot to the working mode.
// ----------------------------------------------------------------------------
module pmu_clause_stage #(
  parameter int SLOT_IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pmu_pkg::pmu_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pmu_pkg::pmu_item_t          out_item,
  input  logic [pmu_pkg::SlotW-1:0]   file_slot,
  input  logic [pmu_pkg::SlotW-1:0]   dir_slot,
  input  logic [pmu_pkg::UmaskW-1:0]  umask
);

  localparam logic [pmu_pkg::CountW-1:0] IdxC = pmu_pkg::CountW'(SLOT_IDX);

  pmu_pkg::pmu_item_t      item_next;
  logic [pmu_pkg::SlotW-1:0] slot;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    slot      = in_item.is_dir ? dir_slot : file_slot;
    item_next = in_item;
    if (in_item.apply && !in_item.octal && (IdxC < in_item.count)) begin
      item_next.work_mode = pmu_pkg::run_clause(in_item.work_mode, slot,
                                                in_item.is_dir, umask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

/* sv/pmu_checker.sv */
// ----------------------------------------------------------------------------
// pmu_port_checks
// Port-level checks on the permission mode update block.
// ----------------------------------------------------------------------------
module pmu_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [pmu_pkg::OutDataW-1:0]    m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic                            cfg_we,
  input logic [pmu_pkg::CfgIndexW-1:0]   cfg_index,
  input logic [pmu_pkg::CfgDataW-1:0]    cfg_data
);

  logic [1:0] own_en;
  logic [3:0] pending;
  logic       s_acc;
  logic       m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_en  <= '0;
      pending <= '0;
    end else begin
      if (cfg_we && (cfg_index == pmu_pkg::REG_OWN_ENABLE)) begin
        own_en <= cfg_data[1:0];
      end
      pending <= pending + 4'(s_acc) - 4'(m_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 4'd0)
    else $error("result without an accepted entry");

  a_owner_gate: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> own_en[0])
    else $error("owner change flagged with enforcement off");

  a_group_gate: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> own_en[1])
    else $error("group change flagged with enforcement off");

endmodule

bind permission_mode_update pmu_port_checks u_pmu_checker (.*);
